// ===== sv/smpq_pkg.sv =====
// ----------------------------------------------------------------------------
// smpq_pkg: shared types and constants of the stable minimum priority queue
// Holds the queue depth, the entry and cell control types and the error codes.
// ----------------------------------------------------------------------------
package smpq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int DATA_W      = 32;
	localparam int CNT_OUT_W   = 5;

	localparam logic ACT_ADD    = 1'b0;
	localparam logic ACT_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		ERR_OK    = 2'd0,
		ERR_FULL  = 2'd1,
		ERR_EMPTY = 2'd2
	} err_code_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] item;
		logic signed [DATA_W-1:0] prio;
	} entry_t;

	// Broadcast to every cell in the row for one accepted beat.
	typedef struct packed {
		logic   add;
		logic   rem;
		entry_t ins;
	} spq_ctrl_t;

endpackage

// ===== sv/smpq_cell.sv =====
// ----------------------------------------------------------------------------
// smpq_cell: one slot of the sorted queue
// Compares its entry with the incoming priority and holds, takes the new
// entry, or takes a neighbor's entry so the row stays sorted and stable.
// ----------------------------------------------------------------------------
module smpq_cell (
	input  logic                clk,
	input  smpq_pkg::spq_ctrl_t ctrl,
	input  logic                occupied,
	input  logic                left_keep,
	input  smpq_pkg::entry_t    left_data,
	input  smpq_pkg::entry_t    right_data,
	output logic                keep,
	output smpq_pkg::entry_t    data,
	output smpq_pkg::entry_t    data_nxt
);
	import smpq_pkg::*;

	entry_t data_q;

	// An equal priority stays in place, so a new entry lands behind it.
	assign keep = occupied && !(data_q.prio > ctrl.ins.prio);
	assign data = data_q;

	always_comb begin
		data_nxt = data_q;
		if (ctrl.add && !keep) begin
			data_nxt = left_keep ? ctrl.ins : left_data;
		end else if (ctrl.rem) begin
			data_nxt = right_data;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_nxt;
	end

endmodule

// ===== sv/stable_min_priority_queue.sv =====
// ----------------------------------------------------------------------------
// stable_min_priority_queue: bounded sorted priority queue, FIFO among ties
// A row of cells kept in ascending priority order, front at cell zero.
// ----------------------------------------------------------------------------
// Each input beat either adds an item or removes the front entry and yields
// exactly one result beat in the next cycle. All cells compare the incoming
// priority in parallel and shift in the same cycle, so the queue takes one
// beat per clock; input is held off only while a result waits unread in the
// output register and the output side is stalled. An add to a full queue is
// dropped with error code 1, a remove from an empty queue changes nothing and
// reports error code 2. There is no clearing pass after reset.
module stable_min_priority_queue (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [63:0]  s_tdata,  // item[31:0], priority_req[63:32]
	input  logic         s_tuser,  // action
	output logic         m_tvalid,
	input  logic         m_tready,
	// removed_item[31:0], head_item[63:32], head_priority[95:64],
	// entry_count[100:96], is_empty[101], error_code[103:102]
	output logic [103:0] m_tdata
);
	import smpq_pkg::*;

	logic             accept;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;
	logic             is_full;
	logic             is_empty_now;
	spq_ctrl_t        ctrl;
	err_code_t        err;
	logic [DATA_W-1:0] removed;

	logic   cell_keep [QUEUE_DEPTH];
	entry_t cell_data [QUEUE_DEPTH];
	entry_t cell_nxt  [QUEUE_DEPTH];

	logic          m_tvalid_q;
	logic [103:0]  m_tdata_q;

	assign s_tready     = !m_tvalid_q || m_tready;
	assign accept       = s_tvalid && s_tready;
	assign is_full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign is_empty_now = (count_q == '0);

	always_comb begin
		ctrl.ins.item = s_tdata[31:0];
		ctrl.ins.prio = s_tdata[63:32];
		ctrl.add      = accept && (s_tuser == ACT_ADD) && !is_full;
		ctrl.rem      = accept && (s_tuser == ACT_REMOVE) && !is_empty_now;

		count_nxt = count_q;
		if (ctrl.add) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (ctrl.rem) begin
			count_nxt = count_q - CNT_W'(1);
		end

		err = ERR_OK;
		if ((s_tuser == ACT_ADD) && is_full) begin
			err = ERR_FULL;
		end else if ((s_tuser == ACT_REMOVE) && is_empty_now) begin
			err = ERR_EMPTY;
		end

		removed = ctrl.rem ? cell_data[0].item : '0;
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic   left_keep;
		entry_t left_data;
		entry_t right_data;

		if (i == 0) begin : g_first
			assign left_keep = 1'b1;
			assign left_data = ctrl.ins;
		end else begin : g_mid
			assign left_keep = cell_keep[i-1];
			assign left_data = cell_data[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign right_data = cell_data[i];
		end else begin : g_body
			assign right_data = cell_data[i+1];
		end

		smpq_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.occupied   (count_q > CNT_W'(i)),
			.left_keep  (left_keep),
			.left_data  (left_data),
			.right_data (right_data),
			.keep       (cell_keep[i]),
			.data       (cell_data[i]),
			.data_nxt   (cell_nxt[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (accept) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_tdata_q[31:0]    <= removed;
			m_tdata_q[63:32]   <= (count_nxt != '0) ? cell_nxt[0].item : '0;
			m_tdata_q[95:64]   <= (count_nxt != '0) ? cell_nxt[0].prio : '0;
			m_tdata_q[100:96]  <= CNT_OUT_W'(count_nxt);
			m_tdata_q[101]     <= (count_nxt == '0);
			m_tdata_q[103:102] <= err;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("entry count exceeds queue depth");

	a_front_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CNT_W'(2)) |-> !(cell_data[0].prio > cell_data[1].prio))
		else $error("front cells out of priority order");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser == ACT_ADD && is_full) |=> (count_q == $past(count_q)))
		else $error("add to a full queue changed the entry count");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (m_tdata_q[101] == (count_q == '0)))
		else $error("empty flag disagrees with entry count");
`endif

endmodule
